@@ rtl/core/olte_pkg.sv @@
`default_nettype none
package olte_pkg;

  localparam int VAL_W   = 32;
  localparam int POS_W   = 6;
  localparam int FOUND_W = 7;
  localparam int CNT_W   = 7;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_FIND   = 2'd2,
    REQ_MAX    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  localparam logic [FOUND_W-1:0] NONE_POS = {FOUND_W{1'b1}};

endpackage
`default_nettype wire

@@ rtl/core/olte_if.sv @@
`default_nettype none
interface olte_in_if;
  import olte_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               req_type;
  logic signed [VAL_W-1:0]  item_value;
  logic [POS_W-1:0]         position;

  modport source (output valid, output req_type, output item_value, output position,
                  input ready);
  modport sink   (input valid, input req_type, input item_value, input position,
                  output ready);
endinterface

interface olte_out_if;
  import olte_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VAL_W-1:0]   removed_value;
  logic signed [FOUND_W-1:0] found_position;
  logic [1:0]                status;
  logic [CNT_W-1:0]          element_count;

  modport source (output valid, output removed_value, output found_position,
                  output status, output element_count, input ready);
  modport sink   (input valid, input removed_value, input found_position,
                  input status, input element_count, output ready);
endinterface
`default_nettype wire

@@ rtl/core/ordered_list_table_engine_core.sv @@
// Ordered list engine: holds up to DEPTH signed 32-bit values in list order.
// in_chan (valid/ready) carries one request: append, delete at position,
// find value, or position of maximum. out_chan (valid/ready) returns one
// result per request: removed value, found position (-1 if none), status
// and element count after the request.
// Append, error cases and find on an empty list go straight to the done
// state and then the output register. Delete, find and max walk the stored
// entries through one RAM read port, one entry per cycle: delete from p to
// the end, find and max from slot 0. Requests are served one at a time;
// in_chan.ready is high only while the sequencer is idle, so no request is
// taken until the last one is done. Delete closes the gap by writing each
// read entry one slot lower on the RAM write port during the same walk.
// Reset: count goes to zero, no result pending; RAM contents are unknown and
// never read before being written. No clearing pass is needed.
// Output stall: the result register holds until out_chan.ready; the next
// request may be taken and walked meanwhile, and waits at completion.
`default_nettype none
module ordered_list_table_engine_core
  import olte_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  olte_in_if.sink     in_chan,
  olte_out_if.source  out_chan
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        len_r, len_nxt;
  req_t                 req_r, req_nxt;
  logic [VAL_W-1:0]     val_r, val_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic [AW-1:0]        last_r, last_nxt;
  logic [AW-1:0]        rd_addr_r, rd_addr_nxt;
  logic                 rd_act_r, rd_act_nxt;
  logic [AW-1:0]        tag_r, tag_nxt;
  logic                 tag_v_r, tag_v_nxt;
  logic [VAL_W-1:0]     removed_r, removed_nxt;
  logic [AW-1:0]        found_r, found_nxt;
  logic                 hit_r, hit_nxt;
  logic [VAL_W-1:0]     best_r, best_nxt;
  status_t              status_r, status_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]     out_removed_r, out_removed_nxt;
  logic [FOUND_W-1:0]   out_found_r, out_found_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [CNT_W-1:0]     out_count_r, out_count_nxt;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [VAL_W-1:0]     wdata;
  logic [VAL_W-1:0]     rd_data;
  logic                 in_fire;

  olte_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr_r),
    .rdata (rd_data)
  );

  assign in_chan.ready           = (state_r == S_IDLE);
  assign in_fire                 = in_chan.valid && in_chan.ready;
  assign out_chan.valid          = out_valid_r;
  assign out_chan.removed_value  = out_removed_r;
  assign out_chan.found_position = out_found_r;
  assign out_chan.status         = out_status_r;
  assign out_chan.element_count  = out_count_r;

  always_comb begin
    state_nxt       = state_r;
    len_nxt         = len_r;
    req_nxt         = req_r;
    val_nxt         = val_r;
    pos_nxt         = pos_r;
    last_nxt        = last_r;
    rd_addr_nxt     = rd_addr_r;
    rd_act_nxt      = 1'b0;
    tag_nxt         = rd_addr_r;
    tag_v_nxt       = rd_act_r;
    removed_nxt     = removed_r;
    found_nxt       = found_r;
    hit_nxt         = hit_r;
    best_nxt        = best_r;
    status_nxt      = status_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_removed_nxt = out_removed_r;
    out_found_nxt   = out_found_r;
    out_status_nxt  = out_status_r;
    out_count_nxt   = out_count_r;
    we              = 1'b0;
    waddr           = tag_r - AW'(1);
    wdata           = rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          req_nxt     = req_t'(in_chan.req_type);
          val_nxt     = in_chan.item_value;
          pos_nxt     = AW'(in_chan.position);
          last_nxt    = AW'(len_r - CW'(1));
          removed_nxt = '0;
          hit_nxt     = 1'b0;
          status_nxt  = ST_OK;
          rd_addr_nxt = '0;
          state_nxt   = S_DONE;
          unique case (req_t'(in_chan.req_type))
            REQ_APPEND: begin
              if (len_r >= CW'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                we      = 1'b1;
                waddr   = AW'(len_r);
                wdata   = in_chan.item_value;
                len_nxt = len_r + CW'(1);
              end
            end
            REQ_DELETE: begin
              if (CMPW'(in_chan.position) >= CMPW'(len_r)) begin
                status_nxt = ST_RANGE;
              end else begin
                rd_addr_nxt = AW'(in_chan.position);
                rd_act_nxt  = 1'b1;
                state_nxt   = S_WALK;
              end
            end
            REQ_FIND: begin
              if (len_r != '0) begin
                rd_act_nxt = 1'b1;
                state_nxt  = S_WALK;
              end
            end
            REQ_MAX: begin
              if (len_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                rd_act_nxt = 1'b1;
                state_nxt  = S_WALK;
              end
            end
            default: ;
          endcase
        end
      end

      S_WALK: begin
        if (rd_act_r) begin
          rd_addr_nxt = rd_addr_r + AW'(1);
          rd_act_nxt  = (rd_addr_r != last_r);
        end
        if (tag_v_r) begin
          unique case (req_r)
            REQ_DELETE: begin
              if (tag_r == pos_r) begin
                removed_nxt = rd_data;
              end else begin
                we = 1'b1;
              end
            end
            REQ_FIND: begin
              if (!hit_r && rd_data == val_r) begin
                hit_nxt   = 1'b1;
                found_nxt = tag_r;
              end
            end
            REQ_MAX: begin
              if (!hit_r || $signed(rd_data) > $signed(best_r)) begin
                hit_nxt   = 1'b1;
                found_nxt = tag_r;
                best_nxt  = rd_data;
              end
            end
            default: ;
          endcase
          if (tag_r == last_r) begin
            state_nxt = S_DONE;
            if (req_r == REQ_DELETE) begin
              len_nxt = len_r - CW'(1);
            end
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt   = 1'b1;
          out_removed_nxt = removed_r;
          out_found_nxt   = hit_r ? FOUND_W'(found_r) : NONE_POS;
          out_status_nxt  = status_r;
          out_count_nxt   = CNT_W'(len_r);
          state_nxt       = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      rd_act_r    <= 1'b0;
      tag_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      rd_act_r    <= rd_act_nxt;
      tag_v_r     <= tag_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    val_r         <= val_nxt;
    pos_r         <= pos_nxt;
    last_r        <= last_nxt;
    rd_addr_r     <= rd_addr_nxt;
    tag_r         <= tag_nxt;
    removed_r     <= removed_nxt;
    found_r       <= found_nxt;
    hit_r         <= hit_nxt;
    best_r        <= best_nxt;
    status_r      <= status_nxt;
    out_removed_r <= out_removed_nxt;
    out_found_r   <= out_found_nxt;
    out_status_r  <= out_status_nxt;
    out_count_r   <= out_count_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/core/olte_ram.sv @@
`default_nettype none
module olte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ dv/ordered_list_table_engine_core_tb.sv @@
`timescale 1ns / 1ps
module ordered_list_table_engine_core_tb;
  import olte_pkg::*;

  localparam int LIST_DEPTH = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = LIST_DEPTH + 16;
  localparam int HOLD_CYCLES = 400;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;

  typedef struct {
    req_t                    req;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        pos;
  } list_req_s;

  typedef struct {
    logic signed [VAL_W-1:0]   removed;
    logic signed [FOUND_W-1:0] found;
    status_t                   status;
    logic [CNT_W-1:0]          count;
  } list_rsp_s;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  olte_in_if  in_chan();
  olte_out_if out_chan();

  ordered_list_table_engine_core #(.DEPTH(LIST_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #2 clk = ~clk;

  list_req_s pending_q[$];
  list_rsp_s expected_rsp_q[$];
  list_req_s in_flight;

  logic signed [VAL_W-1:0] list_mem [LIST_DEPTH];
  int list_len = 0;
  int gen_count = 0;

  int unsigned send_idle_pct = 9;
  int unsigned recv_idle_pct = 71;
  logic hold_start = 1'b0;
  int hold_left = 0;
  int mismatches = 0;
  int rsp_seen = 0;
  int stall_cycles = 0;

  function automatic list_rsp_s serve_request(list_req_s rq);
    list_rsp_s rs;
    int k;
    int best;
    rs.removed = '0;
    rs.found = NONE_POS;
    rs.status = ST_OK;
    case (rq.req)
      REQ_APPEND: begin
        if (list_len >= LIST_DEPTH) begin
          rs.status = ST_FULL;
        end else begin
          list_mem[list_len] = rq.value;
          list_len++;
        end
      end
      REQ_DELETE: begin
        if (int'(rq.pos) >= list_len) begin
          rs.status = ST_RANGE;
        end else begin
          rs.removed = list_mem[rq.pos];
          for (k = int'(rq.pos); k < list_len - 1; k++) list_mem[k] = list_mem[k + 1];
          list_len--;
        end
      end
      REQ_FIND: begin
        for (k = 0; k < list_len; k++) begin
          if (list_mem[k] == rq.value) begin
            rs.found = FOUND_W'(k);
            break;
          end
        end
      end
      default: begin
        if (list_len == 0) begin
          rs.status = ST_EMPTY;
        end else begin
          best = 0;
          for (k = 1; k < list_len; k++) begin
            if (list_mem[k] > list_mem[best]) best = k;
          end
          rs.found = FOUND_W'(best);
        end
      end
    endcase
    rs.count = CNT_W'(list_len);
    return rs;
  endfunction

  function automatic void compare_field(string name, logic [VAL_W-1:0] want,
                                        logic [VAL_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: response %0d field %s expected 0x%08h got 0x%08h",
                 $time, rsp_seen, name, want, got);
    end
  endfunction

  function automatic void check_response();
    list_rsp_s want;
    if (expected_rsp_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: response %0d arrived with no request outstanding", $time, rsp_seen);
    end else begin
      want = expected_rsp_q.pop_front();
      compare_field("removed_value", want.removed, out_chan.removed_value);
      compare_field("found_position", want.found, out_chan.found_position);
      compare_field("status", want.status, out_chan.status);
      compare_field("element_count", want.count, out_chan.element_count);
    end
    rsp_seen++;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) expected_rsp_q.push_back(serve_request(in_flight));
      if (!in_chan.valid || in_chan.ready) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight = pending_q.pop_front();
          in_chan.req_type <= in_flight.req;
          in_chan.item_value <= in_flight.value;
          in_chan.position <= in_flight.pos;
          in_chan.valid <= 1'b1;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) check_response();
      if (hold_start) begin
        hold_start <= 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(3))
      0, 1: return int'($urandom_range(6)) - 3;
      2: begin
        case ($urandom_range(4))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return VAL_MIN + 1;
          3: return VAL_MAX - 1;
          default: return '0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic void push_req(req_t r, logic signed [VAL_W-1:0] v, logic [POS_W-1:0] p);
    list_req_s rq;
    rq.req = r;
    rq.value = v;
    rq.pos = p;
    pending_q.push_back(rq);
    if (r == REQ_APPEND && gen_count < LIST_DEPTH) gen_count++;
    else if (r == REQ_DELETE && int'(p) < gen_count) gen_count--;
  endfunction

  function automatic void add_directed();
    push_req(REQ_MAX, 0, 0);
    push_req(REQ_FIND, 0, 0);
    push_req(REQ_DELETE, 0, 0);
    push_req(REQ_DELETE, 0, 63);
    push_req(REQ_APPEND, VAL_MIN, 0);
    push_req(REQ_APPEND, VAL_MAX, 0);
    push_req(REQ_APPEND, 0, 0);
    push_req(REQ_APPEND, -1, 0);
    push_req(REQ_APPEND, VAL_MAX, 0);
    push_req(REQ_APPEND, 5, 0);
    push_req(REQ_FIND, VAL_MAX, 0);
    push_req(REQ_FIND, VAL_MIN, 0);
    push_req(REQ_FIND, 12345, 0);
    push_req(REQ_MAX, 0, 0);
    push_req(REQ_DELETE, 0, 6);
    push_req(REQ_DELETE, 0, 63);
    push_req(REQ_DELETE, 0, 5);
    push_req(REQ_DELETE, 0, 1);
    push_req(REQ_MAX, 0, 0);
    push_req(REQ_DELETE, 0, 0);
    push_req(REQ_FIND, -1, 0);
    push_req(REQ_MAX, 0, 0);
  endfunction

  // mostly well-formed positions, with runs biased to grow, shrink or query the list
  function automatic void add_random(int n);
    int mode;
    int roll;
    int app_lim;
    int del_lim;
    int find_lim;
    logic [POS_W-1:0] p;
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) mode = $urandom_range(2);
      case (mode)
        0: begin app_lim = 70; del_lim = 80; find_lim = 90; end
        1: begin app_lim = 15; del_lim = 75; find_lim = 88; end
        default: begin app_lim = 25; del_lim = 40; find_lim = 75; end
      endcase
      roll = $urandom_range(99);
      p = POS_W'($urandom_range(63));
      if (roll < app_lim) begin
        push_req(REQ_APPEND, pick_value(), p);
      end else if (roll < del_lim) begin
        if (gen_count > 0 && $urandom_range(99) < 85) p = POS_W'($urandom_range(gen_count - 1));
        push_req(REQ_DELETE, pick_value(), p);
      end else if (roll < find_lim) begin
        push_req(REQ_FIND, pick_value(), p);
      end else begin
        push_req(REQ_MAX, pick_value(), p);
      end
    end
  endfunction

  function automatic void add_fill();
    while (gen_count < LIST_DEPTH) push_req(REQ_APPEND, pick_value(), 0);
    repeat (3) push_req(REQ_APPEND, pick_value(), 0);
    push_req(REQ_MAX, 0, 0);
    push_req(REQ_FIND, pick_value(), 0);
    push_req(REQ_DELETE, pick_value(), 63);
    push_req(REQ_DELETE, pick_value(), 0);
    push_req(REQ_APPEND, VAL_MAX, 0);
    push_req(REQ_APPEND, VAL_MIN, 0);
  endfunction

  // sampled away from the rising edge so the driver's updates are settled
  task automatic wait_drained();
    while (pending_q.size() > 0 || expected_rsp_q.size() > 0 || in_chan.valid)
      @(negedge clk);
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.req_type = REQ_APPEND;
    in_chan.item_value = '0;
    in_chan.position = '0;
    out_chan.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    add_directed();
    add_random(170);
    wait_drained();

    send_idle_pct <= 71;
    recv_idle_pct <= 9;
    add_fill();
    add_random(150);
    wait_drained();

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    add_random(180);
    hold_start <= 1'b1;
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_rsp_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
